>>> rtl/core/dv_pkg.sv
// ----------------------------------------------------------------------------
// dv_pkg: shared types and constants for the 64-bit divider
// Field widths of the stream payload and the control word that travels with
// each request down the divider chain.
// ----------------------------------------------------------------------------
package dv_pkg;

    localparam int FIELD_W     = 64;
    localparam int TUSER_IN_W  = 1;
    localparam int TDATA_IN_W  = 2 * FIELD_W;
    localparam int TDATA_OUT_W = 2 * FIELD_W;

    localparam logic MODE_UNSIGNED = 1'b0;
    localparam logic MODE_SIGNED   = 1'b1;

    typedef struct packed {
        logic valid;
        logic neg_q;
        logic neg_r;
        logic zero;
    } dv_ctl_t;

endpackage

>>> rtl/core/divider_64bit_signed_unsigned.sv
// ----------------------------------------------------------------------------
// A request passes through the prep register, the cell chain and the output register.
// Throughput: one request per cycle while the output is not stalled, one cell of the chain per quotient bit.
// A result held at the output stalls the whole chain until it is taken.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// divider_64bit_signed_unsigned: pipelined restoring divider
// Signed or unsigned division giving quotient and remainder together.
// ----------------------------------------------------------------------------
module divider_64bit_signed_unsigned #(
    parameter int DATA_WIDTH = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [63:0] dividend, [127:64] divisor
    input  logic [dv_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
    // [0] req_type
    input  logic [dv_pkg::TUSER_IN_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [63:0] quotient, [127:64] remainder
    output logic [dv_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import dv_pkg::*;

    localparam int W = DATA_WIDTH;

    logic         advance;
    dv_ctl_t      ctl_s [W+1];
    logic [W-1:0] rem_s [W+1];
    logic [W-1:0] quo_s [W+1];
    logic [W-1:0] den_s [W+1];
    logic [FIELD_W-1:0] quotient;
    logic [FIELD_W-1:0] remainder;

    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;
    assign rem_s[0]      = '0;
    assign m_axis_tdata  = {remainder, quotient};

    dv_prep #(
        .W (W)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_axis_tvalid),
        .req_type (s_axis_tuser[0]),
        .dividend (s_axis_tdata[W-1:0]),
        .divisor  (s_axis_tdata[FIELD_W+W-1:FIELD_W]),
        .ctl_reg  (ctl_s[0]),
        .num_reg  (quo_s[0]),
        .den_reg  (den_s[0])
    );

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        dv_cell #(
            .W (W)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .ctl_in  (ctl_s[i]),
            .rem_in  (rem_s[i]),
            .quo_in  (quo_s[i]),
            .den_in  (den_s[i]),
            .ctl_reg (ctl_s[i+1]),
            .rem_reg (rem_s[i+1]),
            .quo_reg (quo_s[i+1]),
            .den_reg (den_s[i+1])
        );
    end

    dv_post #(
        .W (W)
    ) u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .ctl_in        (ctl_s[W]),
        .quo_in        (quo_s[W]),
        .rem_in        (rem_s[W]),
        .valid_reg     (m_axis_tvalid),
        .quotient_reg  (quotient),
        .remainder_reg (remainder)
    );

`ifndef ASSERT_OFF
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("request taken while result stalled");

    a_chain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s[W].valid && advance |=> m_axis_tvalid)
        else $error("result lost at end of chain");

    a_zero_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s[W].valid && ctl_s[W].zero && advance |=> m_axis_tdata == '0)
        else $error("zero divisor gave non-zero result");

    a_remainder_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_s[W].valid && !ctl_s[W].zero |-> rem_s[W] < den_s[W])
        else $error("remainder not below divisor");
`endif

endmodule

>>> rtl/core/dv_prep.sv
// ----------------------------------------------------------------------------
// dv_prep: operand conditioning stage
// Takes magnitudes of signed operands, records the result signs and the
// zero-divisor case, and registers them at the head of the cell chain.
// ----------------------------------------------------------------------------
module dv_prep #(
    parameter int W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic             req_type,
    input  logic [W-1:0]     dividend,
    input  logic [W-1:0]     divisor,
    output dv_pkg::dv_ctl_t  ctl_reg,
    output logic [W-1:0]     num_reg,
    output logic [W-1:0]     den_reg
);
    import dv_pkg::*;

    logic    num_neg;
    logic    den_neg;
    dv_ctl_t ctl_next;
    logic [W-1:0] num_next;
    logic [W-1:0] den_next;

    always_comb
    begin
        num_neg        = (req_type == MODE_SIGNED) && dividend[W-1];
        den_neg        = (req_type == MODE_SIGNED) && divisor[W-1];
        num_next       = num_neg ? (~dividend + W'(1)) : dividend;
        den_next       = den_neg ? (~divisor + W'(1)) : divisor;
        ctl_next.valid = in_valid;
        ctl_next.neg_q = num_neg ^ den_neg;
        ctl_next.neg_r = num_neg;
        ctl_next.zero  = (divisor == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

endmodule

>>> rtl/core/dv_cell.sv
// ----------------------------------------------------------------------------
// dv_cell: one restoring division step
// Shifts the next dividend bit into the partial remainder, subtracts the
// divisor when it fits and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module dv_cell #(
    parameter int W = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  dv_pkg::dv_ctl_t  ctl_in,
    input  logic [W-1:0]     rem_in,
    input  logic [W-1:0]     quo_in,
    input  logic [W-1:0]     den_in,
    output dv_pkg::dv_ctl_t  ctl_reg,
    output logic [W-1:0]     rem_reg,
    output logic [W-1:0]     quo_reg,
    output logic [W-1:0]     den_reg
);
    import dv_pkg::*;

    logic [W:0]   partial;
    logic [W:0]   diff;
    logic         fits;
    logic [W-1:0] rem_next;
    logic [W-1:0] quo_next;

    always_comb
    begin
        partial  = {rem_in, quo_in[W-1]};
        diff     = partial - {1'b0, den_in};
        fits     = !diff[W];
        rem_next = fits ? diff[W-1:0] : partial[W-1:0];
        quo_next = {quo_in[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_in;
        end
    end

endmodule

>>> rtl/core/dv_post.sv
// ----------------------------------------------------------------------------
// dv_post: result sign fix-up and output register
// Restores the signs of quotient and remainder, forces zero on a zero
// divisor and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module dv_post #(
    parameter int W = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  dv_pkg::dv_ctl_t            ctl_in,
    input  logic [W-1:0]               quo_in,
    input  logic [W-1:0]               rem_in,
    output logic                       valid_reg,
    output logic [dv_pkg::FIELD_W-1:0] quotient_reg,
    output logic [dv_pkg::FIELD_W-1:0] remainder_reg
);
    import dv_pkg::*;

    logic [W-1:0] q_fix;
    logic [W-1:0] r_fix;

    always_comb
    begin
        if (ctl_in.zero)
        begin
            q_fix = '0;
            r_fix = '0;
        end
        else
        begin
            q_fix = ctl_in.neg_q ? (~quo_in + W'(1)) : quo_in;
            r_fix = ctl_in.neg_r ? (~rem_in + W'(1)) : rem_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quotient_reg  <= FIELD_W'(q_fix);
            remainder_reg <= FIELD_W'(r_fix);
        end
    end

endmodule

>>> test/tb_divider_64bit_signed_unsigned.sv
// ----------------------------------------------------------------------------
// tb_divider_64bit_signed_unsigned: stream test of the 64-bit divider
// Sends unsigned and signed division requests and checks every quotient and
// remainder, in order, against a predictor written here in SystemVerilog.
// A short directed set covers the corner operands, then random requests run
// under three idling patterns, with a long output stall and a full drain.
// ----------------------------------------------------------------------------
module tb_divider_64bit_signed_unsigned;

    import dv_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;

    localparam logic [63:0] ALL_ONES = {64{1'b1}};
    localparam logic [63:0] MOST_NEG = {1'b1, 63'd0};
    localparam logic [63:0] MOST_POS = {1'b0, {63{1'b1}}};

    typedef struct packed {
        logic [63:0] quotient;
        logic [63:0] remainder;
    } div_result_t;

    class div_checker;
        div_result_t pending_results[$];
        int          failures;

        function new();
            failures = 0;
        endfunction

        function void report(string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void note_request(logic mode, logic [63:0] num, logic [63:0] den);
            logic [63:0] num_mag;
            logic [63:0] den_mag;
            logic        num_neg;
            logic        den_neg;
            div_result_t res;
            if (den == 64'd0)
            begin
                res.quotient  = 64'd0;
                res.remainder = 64'd0;
            end
            else
            begin
                num_neg = (mode == MODE_SIGNED) && num[63];
                den_neg = (mode == MODE_SIGNED) && den[63];
                num_mag = num_neg ? (~num + 64'd1) : num;
                den_mag = den_neg ? (~den + 64'd1) : den;
                res.quotient  = num_mag / den_mag;
                res.remainder = num_mag % den_mag;
                if (num_neg != den_neg)
                    res.quotient = ~res.quotient + 64'd1;
                if (num_neg)
                    res.remainder = ~res.remainder + 64'd1;
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [63:0] q, logic [63:0] r);
            div_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                report($sformatf("unexpected result: quotient %h remainder %h", q, r));
                return;
            end
            exp_res = pending_results.pop_front();
            if (q !== exp_res.quotient)
                report($sformatf("quotient mismatch: expected %h actual %h",
                                 exp_res.quotient, q));
            if (r !== exp_res.remainder)
                report($sformatf("remainder mismatch: expected %h actual %h",
                                 exp_res.remainder, r));
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void close();
            if (pending_results.size() != 0)
                report($sformatf("%0d results never arrived", pending_results.size()));
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    div_checker sb;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req      = 1'b0;
    int         hold_left     = 0;
    int         stall_cycles  = 0;

    divider_64bit_signed_unsigned #(
        .DATA_WIDTH(64)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tuser[0], s_axis_tdata[63:0], s_axis_tdata[127:64]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[63:0], m_axis_tdata[127:64]);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // receiver: random back-pressure, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = 64'd0;
                    1:       v = 64'd1;
                    2:       v = ALL_ONES;
                    3:       v = MOST_NEG;
                    default: v = MOST_POS;
                endcase
            end
            1, 2:
            begin
                v = 64'($urandom_range(255));
                if ($urandom_range(1))
                    v = ~v + 64'd1;
            end
            3, 4, 5:
                v = v;
            default:
            begin
                v = v >> $urandom_range(63);
                if ($urandom_range(1))
                    v = ~v;
            end
        endcase
        return v;
    endfunction

    // call at a rising edge; returns at the edge where the request is taken
    task automatic send_div(input logic mode, input logic [63:0] num, input logic [63:0] den);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {den, num};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_both_modes(input logic [63:0] num, input logic [63:0] den);
        send_div(MODE_UNSIGNED, num, den);
        send_div(MODE_SIGNED, num, den);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int n, input int s_pct, input int r_pct, input bit with_hold);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int i = 0; i < n; i++)
        begin
            if (with_hold && i == 40)
                hold_req = 1'b1;
            send_div(1'($urandom_range(1)), rand_operand(), rand_operand());
        end
        wait_drained();
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_both_modes(64'd0, 64'd0);
        send_both_modes(ALL_ONES, 64'd0);
        send_both_modes(64'd0, 64'd1);
        send_both_modes(64'd1, ALL_ONES);
        send_both_modes(ALL_ONES, 64'd1);
        send_both_modes(ALL_ONES, ALL_ONES);
        send_both_modes(MOST_NEG, ALL_ONES);
        send_both_modes(MOST_NEG, 64'd1);
        send_both_modes(MOST_NEG, MOST_NEG);
        send_both_modes(MOST_POS, MOST_NEG);
        send_both_modes(64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
        send_both_modes(64'd7, 64'hFFFF_FFFF_FFFF_FFFE);
        send_both_modes(64'hFFFF_FFFF_FFFF_FFF9, 64'hFFFF_FFFF_FFFF_FFFE);
        wait_drained();

        run_random(295, 31, 71, 1'b0);
        run_random(295, 71, 31, 1'b0);
        run_random(295, 0, 0, 1'b1);

        repeat (TAIL_CYCLES) @(posedge clk);
        sb.close();
        if (sb.failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
